FILE: rtl/core/lfd_pkg.sv
// Light flicker detector package: shared widths, register indexes, handshake structs.
// No dependencies.
`default_nettype none
package lfd_pkg;
  localparam int unsigned SampleW = 10;
  localparam int unsigned CountW = 9;
  localparam int unsigned PassW = 4;
  localparam int unsigned SpanEdges = 11;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] RegEdgeThreshold = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinEdges = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxEdges = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPassesNeeded = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpanLimit = 3'd4;

  typedef struct packed {
    logic [SampleW-1:0] light_sample;
  } in_item_t;

  typedef struct packed {
    logic              alarm;
    logic              window_full;
    logic [CountW-1:0] edge_count;
  } out_item_t;

  // Control from the top level into the cell chain.
  typedef struct packed {
    logic clear;   // restart the edge history for a new walk
    logic shift;   // a new edge enters the chain
  } chain_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/core/lfd_if.sv
// Valid/ready channel carrying one payload struct.
// Depends on nothing but the payload type passed as a type parameter.
`default_nettype none
interface lfd_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/light_flicker_detector.sv
// Light flicker detector top level.
// Depends on lfd_pkg, lfd_if, lfd_ram and lfd_chain.
//
// Usage: one light_sample is transferred on the in_ channel; exactly one
// result (alarm, window_full, edge_count) is transferred on the out_ channel
// for every sample. Samples are stored in a WINDOW-entry RAM. Until the
// window is full, S_WRITE goes straight to S_OUT, which loads a result with
// all fields 0; the next sample is taken once S_OUT returns to idle.
// Once full, each sample starts a walk over the window, one entry per cycle
// through the registered RAM read port; edges enter a chain of eleven cells
// holding the newest edge positions. The result is loaded in S_OUT after
// S_WALK and S_EVAL; the next sample is taken once S_OUT returns to idle,
// so each sample waits for the whole walk over the single RAM read port.
// The result sits in an output register; while the receiver stalls, the
// block takes the next sample and starts its walk, but holds the next
// result until the register is freed.
// The user must write registers on the cfg_ port only while idle; the
// block does not enforce this. Writes to an index beyond 4 are ignored.
// Synchronous reset (rst_n low) restores the register defaults, empties
// the window and clears the pass counter.
`default_nettype none
module light_flicker_detector #(
  parameter int unsigned WINDOW = 300
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  lfd_if.sink                                in_ch,
  lfd_if.source                              out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [lfd_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [lfd_pkg::CfgDataW-1:0]  cfg_data
);
  localparam int unsigned AW = $clog2(WINDOW);
  localparam int unsigned PW = $clog2(WINDOW + 1);
  localparam int unsigned CW = (PW > 9) ? PW : 9;
  localparam int unsigned SW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam logic [AW-1:0] LastAddr = AW'(WINDOW - 1);
  localparam logic [PW-1:0] FullLvl = PW'(WINDOW);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_WALK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [9:0] thr_r;
  logic [8:0] min_r, max_r, span_r;
  logic [3:0] need_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 10'd40; min_r <= 9'd5; max_r <= 9'd70; need_r <= 4'd10; span_r <= 9'd120;
    end else if (cfg_we) begin
      case (cfg_index)
        lfd_pkg::RegEdgeThreshold: thr_r  <= cfg_data;
        lfd_pkg::RegMinEdges:      min_r  <= cfg_data[8:0];
        lfd_pkg::RegMaxEdges:      max_r  <= cfg_data[8:0];
        lfd_pkg::RegPassesNeeded:  need_r <= cfg_data[3:0];
        lfd_pkg::RegSpanLimit:     span_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic [AW-1:0] wpos_r, rpos_r;
  logic [PW-1:0] fill_r, k_r, edges_r;
  logic [3:0]    pass_r;
  logic [9:0]    prev_r, smp_r;
  logic          first_r, rd_vld_r, last_rd_r;
  lfd_pkg::out_item_t res_r;
  lfd_pkg::out_item_t res_r_q;
  logic          res_vld_r;
  logic [9:0]    rdata;
  logic          ram_we;

  assign in_ch.ready = (state_r == S_IDLE);
  assign ram_we      = (state_r == S_WRITE);

  lfd_ram #(.Width(10), .Depth(WINDOW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(wpos_r), .wdata(smp_r),
    .raddr(rpos_r), .rdata(rdata));

  // Edge detection on each read-back sample
  logic [9:0] diff;
  logic       is_edge;
  assign diff    = (rdata > prev_r) ? rdata - prev_r : prev_r - rdata;
  assign is_edge = rd_vld_r && !first_r && (diff > thr_r);

  lfd_pkg::chain_ctl_t ctl;
  logic [AW-1:0] pos_newest, pos_oldest;
  logic          span_ok;
  assign ctl.clear = (state_r == S_WRITE);
  assign ctl.shift = is_edge;

  lfd_chain #(.PosW(AW)) u_chain (
    .clk(clk), .ctl(ctl), .pos_new(AW'(k_r)),
    .pos_newest(pos_newest), .pos_oldest(pos_oldest), .span_ok(span_ok));

  logic [3:0] pass_inc;
  logic       pass_hit;
  assign pass_hit = (CW'(edges_r) >= CW'(min_r)) && (CW'(edges_r) <= CW'(max_r));
  assign pass_inc = (pass_hit && pass_r != 4'd15) ? pass_r + 4'd1 : pass_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid) state_nxt = S_WRITE;
      S_WRITE: state_nxt = (fill_r == FullLvl || fill_r == FullLvl - PW'(1)) ? S_WALK : S_OUT;
      S_WALK:  if (last_rd_r && rd_vld_r) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_OUT;
      S_OUT:   if (!res_vld_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wpos_r <= '0; fill_r <= '0; pass_r <= '0;
      res_vld_r <= 1'b0; rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Raise valid when a new result is loaded, drop it once transferred
      if (state_r == S_OUT && (!res_vld_r || out_ch.ready)) begin
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          smp_r <= in_ch.data.light_sample;
        end
        S_WRITE: begin
          wpos_r <= (wpos_r == LastAddr) ? '0 : wpos_r + AW'(1);
          if (fill_r != FullLvl) fill_r <= fill_r + PW'(1);
          // Oldest sample sits at the slot after this write
          rpos_r <= (wpos_r == LastAddr) ? '0 : wpos_r + AW'(1);
          k_r <= '0; edges_r <= '0; first_r <= 1'b1;
          rd_vld_r <= 1'b0; last_rd_r <= 1'b0;
          res_r <= '0;
        end
        S_WALK: begin
          // Advance read address; read data is registered in the RAM
          rd_vld_r  <= !(last_rd_r && rd_vld_r);
          rpos_r    <= (rpos_r == LastAddr) ? '0 : rpos_r + AW'(1);
          if (rd_vld_r) begin
            prev_r  <= rdata;
            first_r <= 1'b0;
            if (is_edge) edges_r <= edges_r + PW'(1);
            if (k_r == PW'(WINDOW - 2)) last_rd_r <= 1'b1;
            if (!last_rd_r) k_r <= k_r + PW'(1);
          end
        end
        S_EVAL: begin
          rd_vld_r <= 1'b0;
          res_r.window_full <= 1'b1;
          res_r.edge_count  <= (CW'(edges_r) > CW'(511)) ? 9'd511 : 9'(edges_r);
          if (pass_inc >= need_r) begin
            res_r.alarm <= span_ok &&
              (SW'(pos_newest) - SW'(pos_oldest) <= SW'(span_r));
            pass_r <= '0;
          end else begin
            res_r.alarm <= 1'b0;
            pass_r <= pass_inc;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid = res_vld_r;
  assign out_ch.data  = res_r_q;

  // Hold the transferred result separately so a new walk cannot disturb it
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!res_vld_r || out_ch.ready)) res_r_q <= res_r;
  end
endmodule
`default_nettype wire

FILE: rtl/core/lfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module lfd_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 300
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and read the array, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/core/lfd_cell.sv
// One cell of the edge-position chain: holds one recorded edge position and
// passes it to its neighbor when a new edge enters. Uses no package items.
`default_nettype none
module lfd_cell #(
  parameter int unsigned PosW = 9
) (
  input  wire logic            clk,
  input  wire logic            clear,
  input  wire logic            shift,
  input  wire logic [PosW-1:0] pos_in,
  input  wire logic            vld_in,
  output logic [PosW-1:0]      pos_r,
  output logic                 vld_r
);
  // Advance the held edge one place on shift, drop it on clear
  always_ff @(posedge clk) begin
    if (clear) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      pos_r <= pos_in;
      vld_r <= vld_in;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/lfd_chain.sv
// Chain of SpanEdges edge cells keeping the positions of the newest edges.
// Depends on lfd_pkg and lfd_cell.
`default_nettype none
module lfd_chain #(
  parameter int unsigned PosW = 9
) (
  input  wire logic                clk,
  input  wire lfd_pkg::chain_ctl_t ctl,
  input  wire logic [PosW-1:0]     pos_new,
  output logic [PosW-1:0]          pos_newest,
  output logic [PosW-1:0]          pos_oldest,
  output logic                     span_ok
);
  localparam int unsigned N = lfd_pkg::SpanEdges;
  logic [PosW-1:0] pos [N];
  logic            vld [N];

  // Cell 0 takes the newest edge, cell N-1 holds the eleventh newest
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      lfd_cell #(.PosW(PosW)) u_cell (
        .clk(clk), .clear(ctl.clear), .shift(ctl.shift),
        .pos_in(pos_new), .vld_in(1'b1), .pos_r(pos[i]), .vld_r(vld[i]));
    end else begin : g_body
      lfd_cell #(.PosW(PosW)) u_cell (
        .clk(clk), .clear(ctl.clear), .shift(ctl.shift),
        .pos_in(pos[i-1]), .vld_in(vld[i-1]), .pos_r(pos[i]), .vld_r(vld[i]));
    end
  end

  assign pos_newest = pos[0];
  assign pos_oldest = pos[N-1];
  assign span_ok    = vld[N-1];
endmodule
`default_nettype wire

FILE: tb/light_flicker_detector_test.sv
// Self-checking testbench for light_flicker_detector: random and directed light samples,
// register sweeps, and a built-in predictor of the flicker window. Depends on lfd_pkg, lfd_if
// and the detector RTL.
`default_nettype none
module light_flicker_detector_test;

  localparam int unsigned WINDOW = 300;
  localparam int unsigned LIMIT_CYCLES = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lfd_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [lfd_pkg::CfgDataW-1:0] cfg_data = '0;

  lfd_if #(.payload_t(lfd_pkg::in_item_t)) in_ch (clk);
  lfd_if #(.payload_t(lfd_pkg::out_item_t)) out_ch (clk);

  light_flicker_detector #(.WINDOW(WINDOW)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state and register copies
  logic [9:0] edge_thr;
  logic [8:0] min_e, max_e, span_lim;
  logic [3:0] passes_req;
  logic [9:0] window_ring [WINDOW];
  int unsigned wr_pos, fill_cnt;
  logic [3:0] pass_cnt;

  lfd_pkg::out_item_t flicker_results[$];
  int errors = 0;
  int sent = 0;
  int alarms_seen = 0;
  int settings_used = 0;
  bit calm = 1'b0;

  // Compute the result for one accepted sample and advance the window.
  function automatic lfd_pkg::out_item_t predict_flicker(logic [9:0] smp);
    lfd_pkg::out_item_t r;
    int unsigned hist [lfd_pkg::SpanEdges];
    int unsigned edges, pos, prev, cur, diff, last, first;
    r = '0;
    edges = 0;
    window_ring[wr_pos] = smp;
    wr_pos = (wr_pos + 1) % WINDOW;
    if (fill_cnt < WINDOW) fill_cnt++;
    if (fill_cnt < WINDOW) return r;
    pos = wr_pos;
    prev = window_ring[pos];
    for (int k = 0; k < WINDOW; k++) begin
      cur = window_ring[pos];
      diff = (cur > prev) ? cur - prev : prev - cur;
      if (diff > edge_thr) begin
        hist[edges % lfd_pkg::SpanEdges] = k;
        edges++;
      end
      prev = cur;
      pos = (pos + 1) % WINDOW;
    end
    if (edges >= min_e && edges <= max_e && pass_cnt < 4'd15) pass_cnt++;
    if (pass_cnt >= passes_req) begin
      if (edges >= lfd_pkg::SpanEdges) begin
        last = hist[(edges - 1) % lfd_pkg::SpanEdges];
        first = hist[(edges - lfd_pkg::SpanEdges) % lfd_pkg::SpanEdges];
        if (last - first <= span_lim) r.alarm = 1'b1;
      end
      pass_cnt = '0;
    end
    r.window_full = 1'b1;
    r.edge_count = (edges > 511) ? 9'd511 : edges[8:0];
    return r;
  endfunction

  task automatic drain();
    while (flicker_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(logic [lfd_pkg::CfgIdxW-1:0] idx,
                           logic [lfd_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      lfd_pkg::RegEdgeThreshold: edge_thr = val;
      lfd_pkg::RegMinEdges: min_e = val[8:0];
      lfd_pkg::RegMaxEdges: max_e = val[8:0];
      lfd_pkg::RegPassesNeeded: passes_req = val[3:0];
      lfd_pkg::RegSpanLimit: span_lim = val[8:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic apply_setting(int thr, int mn, int mx, int pn, int sl);
    drain();
    write_reg(lfd_pkg::RegEdgeThreshold, 10'(thr));
    write_reg(lfd_pkg::RegMinEdges, 10'(mn));
    write_reg(lfd_pkg::RegMaxEdges, 10'(mx));
    write_reg(lfd_pkg::RegPassesNeeded, 10'(pn));
    write_reg(lfd_pkg::RegSpanLimit, 10'(sl));
    settings_used++;
  endtask

  // Transfer one sample, with an optional idle burst first.
  task automatic send_sample(logic [9:0] smp);
    @(negedge clk);
    if (!calm && $urandom_range(0, 9) == 0) repeat ($urandom_range(1, 18)) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data.light_sample = smp;
    do @(posedge clk); while (!in_ch.ready);
    flicker_results = {flicker_results, predict_flicker(smp)};
    sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Square wave of given half period and levels, or random noise when hp is 0.
  task automatic send_wave(int n, int hp, int lo, int hi);
    for (int i = 0; i < n; i++) begin
      if (hp == 0) send_sample(10'($urandom_range(0, 1023)));
      else send_sample(10'(((i / hp) % 2) ? hi : lo));
    end
  endtask

  // Receiver stall bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (calm) begin
      out_ch.ready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready = 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Compare each transferred result with the oldest prediction
  always @(posedge clk) begin
    lfd_pkg::out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (flicker_results.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_ch.data);
        errors++;
      end else begin
        want = flicker_results.pop_front();
        if (want.alarm) alarms_seen++;
        if (out_ch.data.alarm !== want.alarm)
          $display("%0t alarm exp %0d got %0d", $time, want.alarm, out_ch.data.alarm);
        if (out_ch.data.window_full !== want.window_full)
          $display("%0t window_full exp %0d got %0d", $time, want.window_full,
                   out_ch.data.window_full);
        if (out_ch.data.edge_count !== want.edge_count)
          $display("%0t edge_count exp %0d got %0d", $time, want.edge_count,
                   out_ch.data.edge_count);
        if (out_ch.data !== want) errors++;
      end
    end
  end

  // Fill the window with extremes and a ramp; all results stay 0.
  task automatic test_fill();
    send_sample(10'd0);
    send_sample(10'd1023);
    send_sample(10'h2AA);
    send_sample(10'h155);
    for (int i = 4; i < WINDOW - 1; i++) send_sample(10'(i * 3));
  endtask

  // Directed cases right after the window fills, starting at reset register values.
  task automatic test_directed();
    send_sample(10'd1023);           // window fills on this one
    send_wave(12, 5, 100, 900);      // defaults: square wave builds up passes
    apply_setting(0, 0, 299, 1, 299);  // threshold 0: every change is an edge
    send_wave(4, 1, 0, 1023);
    apply_setting(1023, 0, 0, 1, 0);   // nothing exceeds 1023: zero edges pass
    send_wave(3, 1, 0, 1023);
    apply_setting(10, 200, 100, 15, 0); // min above max: never passes
    send_wave(3, 3, 0, 500);
    apply_setting(10, 0, 299, 0, 50);  // check on every sample
    send_wave(3, 2, 0, 500);
    drain();
    write_reg(3'd5, 10'h3FF);          // indexes beyond 4 are dropped
    write_reg(3'd7, 10'h000);
    write_reg(lfd_pkg::RegMinEdges, 10'h3FF);   // masked to 511
    send_sample(10'd7);
  endtask

  // Lower passes_needed below a built-up pass count.
  task automatic test_pass_lowered();
    apply_setting(40, 5, 299, 15, 299);
    send_wave(8, 4, 0, 800);
    apply_setting(40, 5, 299, 2, 299);
    send_wave(3, 4, 0, 800);
    drain(); // sender holds until every result is back
  endtask

  task automatic test_random(int target);
    int hp, lo, hi, thr;
    while (sent < target) begin
      if (target - sent < 150) calm = 1'b1;
      thr = ($urandom_range(0, 5) == 0) ? (($urandom_range(0, 1)) ? 0 : 1023)
                                        : $urandom_range(5, 200);
      if ($urandom_range(0, 3) == 0)
        apply_setting(thr, $urandom_range(0, 299), $urandom_range(0, 299),
                      $urandom_range(0, 15), $urandom_range(0, 299));
      else
        apply_setting(thr, $urandom_range(0, 40), $urandom_range(40, 299),
                      $urandom_range(1, 6), $urandom_range(20, 299));
      hp = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(1, 20);
      lo = $urandom_range(0, 1023);
      hi = $urandom_range(0, 1023);
      send_wave($urandom_range(30, 90), hp, lo, hi);
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    edge_thr = 10'd40;
    min_e = 9'd5;
    max_e = 9'd70;
    passes_req = 4'd10;
    span_lim = 9'd120;
    wr_pos = 0;
    fill_cnt = 0;
    pass_cnt = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_fill();
    test_directed();
    test_pass_lowered();
    test_random(1170);
    drain();
    repeat (WINDOW + 20) @(posedge clk);
    $display("Ran %0d samples over %0d register settings; %0d alarms predicted.",
             sent, settings_used, alarms_seen);
    if (errors == 0 && flicker_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/lfd_pkg.sv
rtl/core/lfd_if.sv
rtl/core/lfd_ram.sv
rtl/core/lfd_cell.sv
rtl/core/lfd_chain.sv
rtl/core/light_flicker_detector.sv
tb/light_flicker_detector_test.sv
